// ===== design/dda_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal adder/subtractor package
// Payload structs, per-digit lane result and shared constants.
// ----------------------------------------------------------------------------
package dda_pkg;

   localparam int DIGIT_W    = 4;
   localparam int MAG_W      = 64;
   localparam int MAX_DIGITS = MAG_W / DIGIT_W;

   localparam logic [DIGIT_W:0] RADIX    = 5'd10;
   localparam logic [DIGIT_W:0] TOP_DIGIT = 5'd9;

   typedef enum logic {
      ACT_ADD = 1'b0,
      ACT_SUB = 1'b1
   } action_type;

   typedef struct packed {
      action_type       action;
      logic [MAG_W-1:0] a_digits;
      logic             a_negative;
      logic [MAG_W-1:0] b_digits;
   } dda_req_type;

   typedef struct packed {
      logic [MAG_W-1:0] sum_digits;
      logic             sum_negative;
      logic             bad_digit;
   } dda_rsp_type;

   // One digit position: carry (or borrow) generate and propagate, the digit
   // for carry-in clear and set, and the per-digit checks.
   typedef struct packed {
      logic               gen;
      logic               prop;
      logic [DIGIT_W-1:0] digit0;
      logic [DIGIT_W-1:0] digit1;
      logic               bad;
      logic               equal;
   } lane_result_type;

endpackage

// ===== design/dda_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit lane
// Works out one digit position for both carry-in values and registers it.
// ----------------------------------------------------------------------------
module dda_lane
   import dda_pkg::*;
(
   input  logic                 clock,
   input  logic                 load,
   input  action_type           action,
   input  logic [DIGIT_W-1:0]   a_digit,
   input  logic [DIGIT_W-1:0]   b_digit,
   output lane_result_type      lane_ff
);

   logic [DIGIT_W:0] a_ext;
   logic [DIGIT_W:0] b_ext;
   logic [DIGIT_W:0] sum0;
   logic [DIGIT_W:0] sum1;
   logic [DIGIT_W:0] sub1;
   lane_result_type  lane_in;

   assign a_ext = {1'b0, a_digit};
   assign b_ext = {1'b0, b_digit};
   assign sum0  = a_ext + b_ext;
   assign sum1  = sum0 + 5'd1;
   assign sub1  = b_ext + 5'd1;

   always_comb begin
      lane_in       = '0;
      lane_in.bad   = (a_ext > TOP_DIGIT) || (b_ext > TOP_DIGIT);
      lane_in.equal = (a_digit == b_digit);
      unique case (action)
         ACT_ADD: begin
            lane_in.gen    = (sum0 >= RADIX);
            lane_in.prop   = (sum0 == TOP_DIGIT);
            lane_in.digit0 = (sum0 >= RADIX) ? DIGIT_W'(sum0 - RADIX) : sum0[DIGIT_W-1:0];
            lane_in.digit1 = (sum1 >= RADIX) ? DIGIT_W'(sum1 - RADIX) : sum1[DIGIT_W-1:0];
         end
         ACT_SUB: begin
            lane_in.gen    = (a_ext < b_ext);
            lane_in.prop   = (a_ext == b_ext);
            lane_in.digit0 = (a_ext < b_ext) ? DIGIT_W'(a_ext + RADIX - b_ext)
                                             : DIGIT_W'(a_ext - b_ext);
            lane_in.digit1 = (a_ext < sub1) ? DIGIT_W'(a_ext + RADIX - sub1)
                                            : DIGIT_W'(a_ext - sub1);
         end
         default: begin
            lane_in.gen    = 1'b0;
            lane_in.prop   = 1'b0;
            lane_in.digit0 = '0;
            lane_in.digit1 = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in;
      end
   end

endmodule

// ===== design/dda_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal lane merge
// Parallel-prefix carry network over the lanes, digit select, sign and
// invalid-digit handling, with the result register.
// ----------------------------------------------------------------------------
module dda_merge
   import dda_pkg::*;
#(
   parameter int DIGITS = 16
)
(
   input  logic                               clock,
   input  logic                               load,
   input  lane_result_type [DIGITS-1:0]       lanes,
   input  action_type                         action,
   input  logic                               a_negative,
   output dda_rsp_type                        rsp_ff
);

   localparam int LEVELS = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [DIGITS-1:0] gen_lvl  [0:LEVELS];
   logic [DIGITS-1:0] prop_lvl [0:LEVELS];
   logic [DIGITS-1:0] carry_in;
   logic              any_bad;
   logic              all_equal;
   dda_rsp_type       rsp_in;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         gen_lvl[0][i]  = lanes[i].gen;
         prop_lvl[0][i] = lanes[i].prop;
      end
      // Logarithmic prefix network: each level doubles the reach of the group.
      for (int l = 0; l < LEVELS; l++) begin
         for (int i = 0; i < DIGITS; i++) begin
            if (i >= (1 << l)) begin
               gen_lvl[l+1][i]  = gen_lvl[l][i]
                                  | (prop_lvl[l][i] & gen_lvl[l][i - (1 << l)]);
               prop_lvl[l+1][i] = prop_lvl[l][i] & prop_lvl[l][i - (1 << l)];
            end else begin
               gen_lvl[l+1][i]  = gen_lvl[l][i];
               prop_lvl[l+1][i] = prop_lvl[l][i];
            end
         end
      end
   end

   always_comb begin
      carry_in  = '0;
      any_bad   = 1'b0;
      all_equal = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         if (i > 0) begin
            carry_in[i] = gen_lvl[LEVELS][i-1];
         end
         any_bad   = any_bad | lanes[i].bad;
         all_equal = all_equal & lanes[i].equal;
      end

      rsp_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         rsp_in.sum_digits[i*DIGIT_W +: DIGIT_W] = carry_in[i] ? lanes[i].digit1
                                                               : lanes[i].digit0;
      end
      rsp_in.sum_negative = a_negative & ~((action == ACT_SUB) & all_equal);

      if (any_bad) begin
         rsp_in.sum_digits   = '0;
         rsp_in.sum_negative = 1'b0;
      end
      rsp_in.bad_digit = any_bad;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== design/decimal_digit_add_sub_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal digit add/subtract unit
// Pipeline: two register stages, the lane stage and then the merge stage; a
// response is valid once its transaction has moved up into the merge stage.
// Throughput: one transaction per cycle; the lane stage and the merge stage
// each hold one transaction and advance together unless the response stalls.
// Reset clears the stage valid flags only; payload registers are not reset.
// ----------------------------------------------------------------------------
module decimal_digit_add_sub_unit
   import dda_pkg::*;
#(
   parameter int DIGITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dda_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dda_rsp_type rsp_payload
);

   logic                          stage_valid_ff;
   logic                          stage_valid_in;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   action_type                    stage_action_ff;
   logic                          stage_negative_ff;
   logic                          rsp_advance;
   logic                          stage_load;
   lane_result_type [DIGITS-1:0]  lanes;

   // The result register may take a new value when empty or being drained;
   // the lane stage then moves up and can refill in the same cycle.
   assign rsp_advance    = ~rsp_valid_ff | rsp_ready;
   assign req_ready      = ~stage_valid_ff | rsp_advance;
   assign stage_load     = req_valid & req_ready;
   assign stage_valid_in = stage_load ? 1'b1 : (stage_valid_ff & ~rsp_advance);
   assign rsp_valid_in   = rsp_advance ? stage_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_load) begin
         stage_action_ff   <= req_payload.action;
         stage_negative_ff <= req_payload.a_negative;
      end
   end

   for (genvar g = 0; g < DIGITS; g++) begin : g_lane
      dda_lane u_lane (
         .clock   (clock),
         .load    (stage_load),
         .action  (req_payload.action),
         .a_digit (req_payload.a_digits[g*DIGIT_W +: DIGIT_W]),
         .b_digit (req_payload.b_digits[g*DIGIT_W +: DIGIT_W]),
         .lane_ff (lanes[g])
      );
   end

   dda_merge #(
      .DIGITS (DIGITS)
   ) u_merge (
      .clock      (clock),
      .load       (rsp_advance & stage_valid_ff),
      .lanes      (lanes),
      .action     (stage_action_ff),
      .a_negative (stage_negative_ff),
      .rsp_ff     (rsp_payload)
   );

   assign rsp_valid = rsp_valid_ff;

   // An invalid digit always yields a positive zero.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.bad_digit |->
         (rsp_payload.sum_digits == '0) && !rsp_payload.sum_negative)
      else $error("bad digit response is not a positive zero");

   // Digit positions above the configured width stay clear.
   a_upper_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.sum_digits >> (DIGITS * DIGIT_W)) == '0))
      else $error("response digits beyond the configured width are set");

   // An accepted request always lands in the lane stage.
   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage_valid_ff)
      else $error("accepted transaction lost at the lane stage");

   // With the response register empty the unit must take requests.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request stalled with an empty response register");

endmodule
